// ----- src/stp_pkg.sv -----
// Shared types, constants and helpers for the sphere-triangle proximity unit.
package stp_pkg;

    localparam int DATA_W      = 32;
    localparam int NORM_W      = 16;
    localparam int RAD_W       = 31;
    localparam int DEN_W       = 23;
    localparam int DIV_STAGES  = DATA_W;
    localparam int D_W         = 27;
    localparam int RECIP_SHIFT = 36;
    localparam int Q_FRAC      = 14;
    localparam int T_SHIFT     = 6;
    localparam int LEN_SHIFT   = 8;
    localparam int NUM_EDGES   = 3;

    // ceil(2^36 / 31): exact quotient for every 31-bit radius.
    localparam logic [DATA_W-1:0] RECIP_31 = 32'd2216757315;

    localparam logic [RAD_W-1:0] RADIUS_RST = 31'd400;
    localparam logic [D_W-1:0]   D_RST      = 27'd12;
    localparam logic [DATA_W-1:0] THR_RST   = 32'd288;

    localparam logic [2:0] DEC_FACE   = 3'd0;
    localparam logic [2:0] DEC_EDGE_R = 3'd1;
    localparam logic [2:0] DEC_EDGE_L = 3'd2;
    localparam logic [2:0] DEC_EDGE_3 = 3'd3;
    localparam logic [2:0] DEC_VERT_A = 3'd4;
    localparam logic [2:0] DEC_VERT_R = 3'd5;
    localparam logic [2:0] DEC_NONE   = 3'd6;

    typedef logic [DATA_W-1:0] word_t;

    typedef struct packed {
        word_t x;
        word_t y;
        word_t z;
    } vec3_t;

    // Projection plane and normal sign chosen for the face test.
    typedef enum logic [2:0] {
        PL_YN,
        PL_YP,
        PL_XP,
        PL_XN,
        PL_ZN,
        PL_ZP
    } plane_t;

    // One edge-side term: a*b + c*d.
    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } cross_ops_t;

    typedef struct packed {
        cross_ops_t c1;
        cross_ops_t c2;
        cross_ops_t c3;
    } face_ops_t;

    // Item context that travels alongside the edge divisions.
    typedef struct packed {
        vec3_t                p;
        vec3_t                l;
        vec3_t                r;
        vec3_t                dr;
        vec3_t                lr;
        logic [NUM_EDGES-1:0] eok;
        logic [NUM_EDGES-1:0] neg;
        logic                 face;
        logic [2:0]           vnear;
    } ctx_t;

    function automatic vec3_t vsub(vec3_t a, vec3_t b);
        vec3_t o;
        o.x = a.x - b.x;
        o.y = a.y - b.y;
        o.z = a.z - b.z;
        return o;
    endfunction

    function automatic cross_ops_t xop(word_t a, word_t b, word_t c, word_t d);
        cross_ops_t o;
        o.a = a;
        o.b = b;
        o.c = c;
        o.d = d;
        return o;
    endfunction

    // Operand selection for the edge-side terms c1, c2 and c3 of each projection.
    function automatic face_ops_t face_ops(plane_t pl, vec3_t p, vec3_t l, vec3_t r,
                                           vec3_t dl, vec3_t dr, vec3_t rl, vec3_t lr);
        face_ops_t o;
        vec3_t     nl;
        vec3_t     nr;
        nl = vsub('0, l);
        nr = vsub('0, r);
        unique case (pl)
            PL_YN: begin
                o.c1 = xop(p.z, l.x, p.x, nl.z);
                o.c2 = xop(dr.x, r.z, dr.z, nr.x);
                o.c3 = xop(dl.x, lr.z, dl.z, rl.x);
            end
            PL_YP: begin
                o.c1 = xop(dl.x, l.z, dl.z, nl.x);
                o.c2 = xop(p.z, r.x, p.x, nr.z);
                o.c3 = xop(rl.z, dr.x, dr.z, lr.x);
            end
            PL_XP: begin
                o.c1 = xop(dl.z, l.y, dl.y, nl.z);
                o.c2 = xop(p.y, r.z, p.z, nr.y);
                o.c3 = xop(dr.z, rl.y, dr.y, lr.z);
            end
            PL_XN: begin
                o.c1 = xop(p.y, l.z, p.z, nl.y);
                o.c2 = xop(dr.z, r.y, dr.y, nr.z);
                o.c3 = xop(dl.y, rl.z, dl.z, lr.y);
            end
            PL_ZN: begin
                o.c1 = xop(dl.x, l.y, dl.y, nl.x);
                o.c2 = xop(p.y, r.x, p.x, nr.y);
                o.c3 = xop(rl.y, dr.x, dr.y, lr.x);
            end
            PL_ZP: begin
                o.c1 = xop(p.y, l.x, p.x, nl.y);
                o.c2 = xop(dr.x, r.y, dr.y, nr.x);
                o.c3 = xop(dl.y, rl.x, dl.x, lr.y);
            end
            default: begin
                o = '0;
            end
        endcase
        return o;
    endfunction

    function automatic vec3_t edge_d(ctx_t c, int k);
        vec3_t o;
        case (k)
            0:       o = c.p;
            1:       o = c.p;
            default: o = c.dr;
        endcase
        return o;
    endfunction

    function automatic vec3_t edge_e(ctx_t c, int k);
        vec3_t o;
        case (k)
            0:       o = c.r;
            1:       o = c.l;
            default: o = c.lr;
        endcase
        return o;
    endfunction

endpackage

// ----- src/stp_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, unsigned.
module stp_div
    import stp_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  word_t            dvd_in,
    input  logic [DEN_W-1:0] den_in,
    output word_t            quo_out
);

    logic [DEN_W-1:0] rem_reg  [DIV_STAGES];
    word_t            dvd_reg  [DIV_STAGES];
    word_t            quo_reg  [DIV_STAGES];
    logic [DEN_W-1:0] den_reg  [DIV_STAGES];

    logic [DEN_W-1:0] rem_next [DIV_STAGES];
    word_t            dvd_next [DIV_STAGES];
    word_t            quo_next [DIV_STAGES];
    logic [DEN_W-1:0] den_next [DIV_STAGES];

    always_comb begin
        logic [DEN_W-1:0] rem_src;
        word_t            dvd_src;
        word_t            quo_src;
        logic [DEN_W-1:0] den_src;
        logic [DEN_W:0]   trial;
        logic             ge;
        for (int j = 0; j < DIV_STAGES; j++) begin
            if (j == 0) begin
                rem_src = '0;
                dvd_src = dvd_in;
                quo_src = '0;
                den_src = den_in;
            end else begin
                rem_src = rem_reg[j-1];
                dvd_src = dvd_reg[j-1];
                quo_src = quo_reg[j-1];
                den_src = den_reg[j-1];
            end
            trial       = {rem_src, dvd_src[DATA_W-1]};
            ge          = (trial >= {1'b0, den_src});
            rem_next[j] = ge ? DEN_W'(trial - {1'b0, den_src}) : trial[DEN_W-1:0];
            dvd_next[j] = {dvd_src[DATA_W-2:0], 1'b0};
            quo_next[j] = {quo_src[DATA_W-2:0], ge};
            den_next[j] = den_src;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
            quo_reg <= quo_next;
            den_reg <= den_next;
        end
    end

    assign quo_out = quo_reg[DIV_STAGES-1];

endmodule

// ----- src/sphere_triangle_proximity_test_unit.sv -----
// Throughput: one item per cycle; the pipeline stalls only when the skid stage
// behind a held output is full.
// The edge divisions set the depth: a 32-stage divider per edge, one quotient bit a stage.
// Reset clears the valid bits, including those of the output and skid stages, and sets radius to 400.
module sphere_triangle_proximity_test_unit
    import stp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_point_z,
    input  logic signed [DATA_W-1:0] s_point_y,
    input  logic signed [DATA_W-1:0] s_point_x,
    input  logic signed [DATA_W-1:0] s_left_z,
    input  logic signed [DATA_W-1:0] s_left_y,
    input  logic signed [DATA_W-1:0] s_left_x,
    input  logic signed [DATA_W-1:0] s_right_z,
    input  logic signed [DATA_W-1:0] s_right_y,
    input  logic signed [DATA_W-1:0] s_right_x,
    input  logic signed [NORM_W-1:0] s_normal_z,
    input  logic signed [NORM_W-1:0] s_normal_y,
    input  logic signed [NORM_W-1:0] s_normal_x,
    input  logic                     cfg_we,
    input  logic [RAD_W-1:0]         cfg_wdata,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_hit,
    output logic [2:0]               m_decided_by
);

    // ---------------- threshold from radius ----------------
    logic [RAD_W-1:0]  radius_reg;
    logic [D_W-1:0]    d_reg;
    logic [DATA_W-1:0] thr_reg;
    logic [62:0]       rprod;
    logic [2*D_W-1:0]  dsq;

    assign rprod = {32'b0, radius_reg} * {31'b0, RECIP_31};
    assign dsq   = {{D_W{1'b0}}, d_reg} * {{D_W{1'b0}}, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RST;
            d_reg      <= D_RST;
            thr_reg    <= THR_RST;
        end else begin
            if (cfg_we) begin
                radius_reg <= cfg_wdata;
            end
            d_reg   <= rprod[RECIP_SHIFT +: D_W];
            thr_reg <= {dsq[DATA_W-2:0], 1'b0};
        end
    end

    // ---------------- flow control ----------------
    logic en;
    logic skid_valid_reg;
    logic m_valid_reg;

    assign en      = ~skid_valid_reg;
    assign s_ready = en;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic vd_reg [DIV_STAGES];
    logic v6_reg, v7_reg, v8_reg, v9_reg, v10_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            vd_reg  <= '{default: 1'b0};
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
        end else if (en) begin
            v1_reg    <= s_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            vd_reg[0] <= v5_reg;
            for (int j = 1; j < DIV_STAGES; j++) begin
                vd_reg[j] <= vd_reg[j-1];
            end
            v6_reg  <= vd_reg[DIV_STAGES-1];
            v7_reg  <= v6_reg;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
        end
    end

    // ---------------- stage 1: input registers ----------------
    vec3_t             p1_reg, l1_reg, r1_reg;
    logic [NORM_W-1:0] nx1_reg, ny1_reg, nz1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg  <= '{x: s_point_x, y: s_point_y, z: s_point_z};
            l1_reg  <= '{x: s_left_x,  y: s_left_y,  z: s_left_z};
            r1_reg  <= '{x: s_right_x, y: s_right_y, z: s_right_z};
            nx1_reg <= s_normal_x;
            ny1_reg <= s_normal_y;
            nz1_reg <= s_normal_z;
        end
    end

    // ---------------- stage 2: differences, plane, face operands ----------------
    vec3_t           dl2_next, dr2_next, rl2_next, lr2_next;
    logic [NORM_W:0] ax2, ay2, az2;
    plane_t          plane2;

    function automatic logic [NORM_W:0] nabs(logic [NORM_W-1:0] n);
        logic [NORM_W:0] e;
        e = {n[NORM_W-1], n};
        return n[NORM_W-1] ? (NORM_W+1)'(~e + 1'b1) : e;
    endfunction

    always_comb begin
        dl2_next = vsub(p1_reg, l1_reg);
        dr2_next = vsub(p1_reg, r1_reg);
        rl2_next = vsub(r1_reg, l1_reg);
        lr2_next = vsub(l1_reg, r1_reg);
        ax2 = nabs(nx1_reg);
        ay2 = nabs(ny1_reg);
        az2 = nabs(nz1_reg);
        // Y wins ties, then Z, then X.
        if (az2 <= ay2 && ax2 <= ay2) begin
            plane2 = ny1_reg[NORM_W-1] ? PL_YN : PL_YP;
        end else if (az2 < ay2 || az2 < ax2) begin
            plane2 = nx1_reg[NORM_W-1] ? PL_XN : PL_XP;
        end else begin
            plane2 = nz1_reg[NORM_W-1] ? PL_ZN : PL_ZP;
        end
    end

    vec3_t     p2_reg, l2_reg, r2_reg, dl2_reg, dr2_reg, lr2_reg;
    face_ops_t fo2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_reg  <= p1_reg;
            l2_reg  <= l1_reg;
            r2_reg  <= r1_reg;
            dl2_reg <= dl2_next;
            dr2_reg <= dr2_next;
            lr2_reg <= lr2_next;
            fo2_reg <= face_ops(plane2, p1_reg, l1_reg, r1_reg,
                                dl2_next, dr2_next, rl2_next, lr2_next);
        end
    end

    // ---------------- stage 3: products ----------------
    function automatic vec3_t vmul(vec3_t a, vec3_t b);
        vec3_t o;
        o.x = a.x * b.x;
        o.y = a.y * b.y;
        o.z = a.z * b.z;
        return o;
    endfunction

    vec3_t ed2 [NUM_EDGES];
    vec3_t ee2 [NUM_EDGES];
    vec3_t vv2 [3];

    always_comb begin
        ed2[0] = p2_reg;
        ee2[0] = r2_reg;
        ed2[1] = p2_reg;
        ee2[1] = l2_reg;
        ed2[2] = dr2_reg;
        ee2[2] = lr2_reg;
        vv2[0] = p2_reg;
        vv2[1] = dl2_reg;
        vv2[2] = dr2_reg;
    end

    word_t fp3_reg [3][2];
    vec3_t tp3_reg [NUM_EDGES];
    vec3_t lp3_reg [NUM_EDGES];
    vec3_t vp3_reg [3];
    vec3_t p3_reg, l3_reg, r3_reg, dr3_reg, lr3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            fp3_reg[0][0] <= fo2_reg.c1.a * fo2_reg.c1.b;
            fp3_reg[0][1] <= fo2_reg.c1.c * fo2_reg.c1.d;
            fp3_reg[1][0] <= fo2_reg.c2.a * fo2_reg.c2.b;
            fp3_reg[1][1] <= fo2_reg.c2.c * fo2_reg.c2.d;
            fp3_reg[2][0] <= fo2_reg.c3.a * fo2_reg.c3.b;
            fp3_reg[2][1] <= fo2_reg.c3.c * fo2_reg.c3.d;
            for (int k = 0; k < NUM_EDGES; k++) begin
                tp3_reg[k] <= vmul(ed2[k], ee2[k]);
                lp3_reg[k] <= vmul(ee2[k], ee2[k]);
            end
            for (int k = 0; k < 3; k++) begin
                vp3_reg[k] <= vmul(vv2[k], vv2[k]);
            end
            p3_reg  <= p2_reg;
            l3_reg  <= l2_reg;
            r3_reg  <= r2_reg;
            dr3_reg <= dr2_reg;
            lr3_reg <= lr2_reg;
        end
    end

    // ---------------- stage 4: sums ----------------
    function automatic word_t vsum(vec3_t a);
        return a.x + a.y + a.z;
    endfunction

    logic  face4_reg;
    word_t t4_reg   [NUM_EDGES];
    word_t len4_reg [NUM_EDGES];
    word_t vs4_reg  [3];
    vec3_t p4_reg, l4_reg, r4_reg, dr4_reg, lr4_reg;

    always_ff @(posedge aclk) begin
        word_t c1, c2, c3;
        c1 = fp3_reg[0][0] + fp3_reg[0][1];
        c2 = fp3_reg[1][0] + fp3_reg[1][1];
        c3 = fp3_reg[2][0] + fp3_reg[2][1];
        if (en) begin
            face4_reg <= ~c1[DATA_W-1] & ~c2[DATA_W-1] & ~c3[DATA_W-1];
            for (int k = 0; k < NUM_EDGES; k++) begin
                t4_reg[k]   <= vsum(tp3_reg[k]);
                len4_reg[k] <= vsum(lp3_reg[k]);
            end
            for (int k = 0; k < 3; k++) begin
                vs4_reg[k] <= vsum(vp3_reg[k]);
            end
            p4_reg  <= p3_reg;
            l4_reg  <= l3_reg;
            r4_reg  <= r3_reg;
            dr4_reg <= dr3_reg;
            lr4_reg <= lr3_reg;
        end
    end

    // ---------------- stage 5: edge range check, divisor, dividend ----------------
    ctx_t             ctx5_next;
    word_t            mag5_next [NUM_EDGES];
    logic [DEN_W-1:0] den5_next [NUM_EDGES];

    always_comb begin
        word_t s;
        word_t len;
        ctx5_next.p    = p4_reg;
        ctx5_next.l    = l4_reg;
        ctx5_next.r    = r4_reg;
        ctx5_next.dr   = dr4_reg;
        ctx5_next.lr   = lr4_reg;
        ctx5_next.face = face4_reg;
        for (int k = 0; k < 3; k++) begin
            ctx5_next.vnear[k] = ($signed(vs4_reg[k]) < $signed(thr_reg));
        end
        for (int k = 0; k < NUM_EDGES; k++) begin
            len = len4_reg[k];
            ctx5_next.eok[k] = ~t4_reg[k][DATA_W-1] &&
                               ($signed(t4_reg[k]) <= $signed(len));
            // A negative or sub-256 length leaves a divisor of one.
            if (len[DATA_W-1] || (len[DATA_W-1:LEN_SHIFT] == '0)) begin
                den5_next[k] = DEN_W'(1);
            end else begin
                den5_next[k] = len[DATA_W-2:LEN_SHIFT];
            end
            s = t4_reg[k] << T_SHIFT;
            ctx5_next.neg[k] = s[DATA_W-1];
            mag5_next[k] = s[DATA_W-1] ? word_t'(~s + 1'b1) : s;
        end
    end

    word_t            mag5_reg [NUM_EDGES];
    logic [DEN_W-1:0] den5_reg [NUM_EDGES];
    ctx_t             ctx5_reg;
    ctx_t             ctxd_reg [DIV_STAGES];

    always_ff @(posedge aclk) begin
        if (en) begin
            mag5_reg    <= mag5_next;
            den5_reg    <= den5_next;
            ctx5_reg    <= ctx5_next;
            ctxd_reg[0] <= ctx5_reg;
            for (int j = 1; j < DIV_STAGES; j++) begin
                ctxd_reg[j] <= ctxd_reg[j-1];
            end
        end
    end

    // ---------------- edge dividers ----------------
    word_t quo [NUM_EDGES];

    for (genvar k = 0; k < NUM_EDGES; k++) begin : g_div
        stp_div u_div (
            .aclk    (aclk),
            .en      (en),
            .dvd_in  (mag5_reg[k]),
            .den_in  (den5_reg[k]),
            .quo_out (quo[k])
        );
    end

    // ---------------- stage 6: signed quotient ----------------
    word_t q6_reg [NUM_EDGES];
    ctx_t  ctx6_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NUM_EDGES; k++) begin
                q6_reg[k] <= ctxd_reg[DIV_STAGES-1].neg[k] ? word_t'(~quo[k] + 1'b1)
                                                           : quo[k];
            end
            ctx6_reg <= ctxd_reg[DIV_STAGES-1];
        end
    end

    // ---------------- stage 7: quotient times edge ----------------
    vec3_t qe7_reg [NUM_EDGES];
    ctx_t  ctx7_reg;

    always_ff @(posedge aclk) begin
        vec3_t e;
        if (en) begin
            for (int k = 0; k < NUM_EDGES; k++) begin
                e = edge_e(ctx6_reg, k);
                qe7_reg[k].x <= q6_reg[k] * e.x;
                qe7_reg[k].y <= q6_reg[k] * e.y;
                qe7_reg[k].z <= q6_reg[k] * e.z;
            end
            ctx7_reg <= ctx6_reg;
        end
    end

    // ---------------- stage 8: residual from the edge ----------------
    function automatic word_t asr_q(word_t x);
        return word_t'($signed(x) >>> Q_FRAC);
    endfunction

    vec3_t res8_reg [NUM_EDGES];
    ctx_t  ctx8_reg;

    always_ff @(posedge aclk) begin
        vec3_t d;
        if (en) begin
            for (int k = 0; k < NUM_EDGES; k++) begin
                d = edge_d(ctx7_reg, k);
                res8_reg[k].x <= d.x - asr_q(qe7_reg[k].x);
                res8_reg[k].y <= d.y - asr_q(qe7_reg[k].y);
                res8_reg[k].z <= d.z - asr_q(qe7_reg[k].z);
            end
            ctx8_reg <= ctx7_reg;
        end
    end

    // ---------------- stage 9: squares ----------------
    vec3_t sq9_reg [NUM_EDGES];
    ctx_t  ctx9_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NUM_EDGES; k++) begin
                sq9_reg[k] <= vmul(res8_reg[k], res8_reg[k]);
            end
            ctx9_reg <= ctx8_reg;
        end
    end

    // ---------------- stage 10: squared distance ----------------
    word_t es10_reg [NUM_EDGES];
    ctx_t  ctx10_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NUM_EDGES; k++) begin
                es10_reg[k] <= vsum(sq9_reg[k]);
            end
            ctx10_reg <= ctx9_reg;
        end
    end

    // ---------------- decision ----------------
    logic [NUM_EDGES-1:0] enear;
    logic                 push;
    logic                 push_hit;
    logic [2:0]           push_dec;

    always_comb begin
        for (int k = 0; k < NUM_EDGES; k++) begin
            enear[k] = ctx10_reg.eok[k] && ($signed(es10_reg[k]) < $signed(thr_reg));
        end
        push_hit = 1'b1;
        if (ctx10_reg.face) begin
            push_dec = DEC_FACE;
        end else if (enear[0]) begin
            push_dec = DEC_EDGE_R;
        end else if (enear[1]) begin
            push_dec = DEC_EDGE_L;
        end else if (enear[2]) begin
            push_dec = DEC_EDGE_3;
        end else if (ctx10_reg.vnear[0] || ctx10_reg.vnear[1]) begin
            push_dec = DEC_VERT_A;
        end else if (ctx10_reg.vnear[2]) begin
            push_dec = DEC_VERT_R;
        end else begin
            push_dec = DEC_NONE;
            push_hit = 1'b0;
        end
    end

    assign push = en & v10_reg;

    // ---------------- output register with skid stage ----------------
    logic       hit_reg, skid_hit_reg;
    logic [2:0] dec_reg, skid_dec_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                hit_reg <= skid_hit_reg;
                dec_reg <= skid_dec_reg;
            end else begin
                hit_reg <= push_hit;
                dec_reg <= push_dec;
            end
        end else if (push) begin
            skid_hit_reg <= push_hit;
            skid_dec_reg <= push_dec;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hit        = hit_reg;
    assign m_decided_by = dec_reg;

endmodule
